// File: rtl/core/rif_pkg.sv
`default_nettype none

package rif_pkg;

  // Table geometry
  localparam int unsigned CHROM_TOTAL   = 64;
  localparam int unsigned MAX_INTERVALS = 16;
  localparam int unsigned POS_BITS      = 32;

  // Fixed field widths of the channels
  localparam int unsigned OP_W     = 2;
  localparam int unsigned CHROM_W  = 6;
  localparam int unsigned FIELD_W  = 32;
  localparam int unsigned STATUS_W = 2;

  // Derived widths and depths
  localparam int unsigned CHROM_AW    = (CHROM_TOTAL > 1) ? $clog2(CHROM_TOTAL) : 1;
  localparam int unsigned SLOT_W      = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1;
  localparam int unsigned CNT_W       = $clog2(MAX_INTERVALS + 1);
  localparam int unsigned STORE_AW    = CHROM_AW + SLOT_W;
  localparam int unsigned STORE_DEPTH = CHROM_TOTAL << SLOT_W;
  localparam int unsigned STORE_W     = 2 * POS_BITS;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_SITE   = 2'd2,
    OP_RANGE  = 2'd3
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_DROPPED = 2'd1,
    ST_MULTI   = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_COUNT,
    S_SCAN,
    S_REPLY
  } state_e;

  typedef logic [POS_BITS-1:0] pos_t;

  typedef struct packed {
    pos_t first;
    pos_t last;
  } span_t;

  typedef struct packed {
    logic                rd_en;
    logic [CHROM_AW-1:0] rd_addr;
    logic                wr_en;
    logic [CHROM_AW-1:0] wr_addr;
    logic [CNT_W-1:0]    wr_count;
    logic                clear_all;
  } cnt_req_t;

  typedef struct packed {
    logic                rd_en;
    logic [STORE_AW-1:0] rd_addr;
    logic                wr_en;
    logic [STORE_AW-1:0] wr_addr;
    span_t               wr_data;
  } store_req_t;

endpackage

`default_nettype wire

// File: rtl/core/rif_in_if.sv
`default_nettype none

interface rif_in_if;
  import rif_pkg::*;

  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     opcode;
  logic [CHROM_W-1:0]  chrom_index;
  logic [FIELD_W-1:0]  first_pos;
  logic [FIELD_W-1:0]  last_pos;

  modport source (
    output valid, opcode, chrom_index, first_pos, last_pos,
    input  ready
  );

  modport sink (
    input  valid, opcode, chrom_index, first_pos, last_pos,
    output ready
  );

endinterface

`default_nettype wire

// File: rtl/core/rif_out_if.sv
`default_nettype none

interface rif_out_if;
  import rif_pkg::*;

  logic                valid;
  logic                ready;
  logic                hit;
  logic [FIELD_W-1:0]  clip_start;
  logic [FIELD_W-1:0]  clip_end;
  logic [STATUS_W-1:0] status;

  modport source (
    output valid, hit, clip_start, clip_end, status,
    input  ready
  );

  modport sink (
    input  valid, hit, clip_start, clip_end, status,
    output ready
  );

endinterface

`default_nettype wire

// File: rtl/core/region_interval_filter_core.sv
`default_nettype none

// Channel   Dir  Handshake      Word
// req_i     in   valid/ready    opcode, chrom_index, first_pos, last_pos
// rsp_o     out  valid/ready    hit, clip_start, clip_end, status
// cfg       in   cfg_we_i       cfg_wdata_i (filter enable)
//
// One word is in flight at a time. Clear, append, disabled queries and queries
// on an empty list pass from S_COUNT through S_REPLY to the output register.
// An enabled query on a non-empty list first scans its intervals in S_SCAN,
// examining at most MAX_INTERVALS, through the interval store's single read port.
// Reset clears the list counts and the filter enable; the interval store is not
// cleared. A stalled result waits in the output register while the next word
// is accepted and worked on; it finishes only after the pending result leaves.

module region_interval_filter_core (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic cfg_we_i,
  input  wire logic cfg_wdata_i,
  rif_in_if.sink    req_i,
  rif_out_if.source rsp_o
);
  import rif_pkg::*;

  logic             filter_enabled_q;
  cnt_req_t         cnt_req;
  store_req_t       store_req;
  logic [CNT_W-1:0] count;
  span_t            store_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filter_enabled_q <= 1'b0;
    end else if (cfg_we_i) begin
      filter_enabled_q <= cfg_wdata_i;
    end
  end

  rif_seq u_seq (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .req_i            (req_i),
    .rsp_o            (rsp_o),
    .filter_enabled_i (filter_enabled_q),
    .count_i          (count),
    .store_rdata_i    (store_rdata),
    .cnt_req_o        (cnt_req),
    .store_req_o      (store_req)
  );

  rif_count_table u_count_table (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (cnt_req),
    .count_o (count)
  );

  rif_ram #(
    .WIDTH (STORE_W),
    .DEPTH (STORE_DEPTH)
  ) u_store_ram (
    .clk_i   (clk_i),
    .we_i    (store_req.wr_en),
    .waddr_i (store_req.wr_addr),
    .wdata_i (store_req.wr_data),
    .re_i    (store_req.rd_en),
    .raddr_i (store_req.rd_addr),
    .rdata_o (store_rdata)
  );

  // An interval is stored only together with the count update of its list.
  a_store_with_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    store_req.wr_en |-> cnt_req.wr_en)
    else $error("interval stored without a count update");

  // A clear never coincides with an append.
  a_clear_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_req.clear_all |-> (!cnt_req.wr_en && !store_req.wr_en))
    else $error("clear overlaps an append");

  // Only one word is worked on at a time.
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> !req_i.ready)
    else $error("second word accepted while one is in flight");

  // The count read and the interval scan never share a cycle.
  a_reads_apart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    store_req.rd_en |-> !cnt_req.rd_en)
    else $error("count read during interval scan");

endmodule

`default_nettype wire

// File: rtl/core/rif_ram.sv
`default_nettype none

module rif_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: rtl/core/rif_count_table.sv
`default_nettype none

module rif_count_table (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire rif_pkg::cnt_req_t              req_i,
  output logic      [rif_pkg::CNT_W-1:0]      count_o
);
  import rif_pkg::*;

  // One valid bit per chromosome: a list whose bit is low reads as empty,
  // so a clear only resets the valid bits and the RAM needs no sweep.
  logic [CHROM_TOTAL-1:0] valid_q;
  logic                   rd_valid_q;
  logic [CNT_W-1:0]       ram_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (req_i.clear_all) begin
        valid_q <= '0;
      end else if (req_i.wr_en) begin
        valid_q[req_i.wr_addr] <= 1'b1;
      end
      if (req_i.rd_en) begin
        rd_valid_q <= valid_q[req_i.rd_addr];
      end
    end
  end

  rif_ram #(
    .WIDTH (CNT_W),
    .DEPTH (CHROM_TOTAL)
  ) u_count_ram (
    .clk_i   (clk_i),
    .we_i    (req_i.wr_en),
    .waddr_i (req_i.wr_addr),
    .wdata_i (req_i.wr_count),
    .re_i    (req_i.rd_en),
    .raddr_i (req_i.rd_addr),
    .rdata_o (ram_rdata)
  );

  assign count_o = rd_valid_q ? ram_rdata : '0;

endmodule

`default_nettype wire

// File: rtl/core/rif_seq.sv
`default_nettype none

module rif_seq (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  rif_in_if.sink                         req_i,
  rif_out_if.source                      rsp_o,
  input  wire logic                      filter_enabled_i,
  input  wire logic [rif_pkg::CNT_W-1:0] count_i,
  input  wire rif_pkg::span_t            store_rdata_i,
  output rif_pkg::cnt_req_t              cnt_req_o,
  output rif_pkg::store_req_t            store_req_o
);
  import rif_pkg::*;

  state_e              state_q, state_d;
  op_e                 op_q;
  logic [CHROM_AW-1:0] chrom_q;
  logic                chrom_ok_q;
  pos_t                first_q, last_q;
  logic [CNT_W-1:0]    n_q, n_d;
  logic [SLOT_W-1:0]   slot_q, slot_d;

  logic                res_load;
  logic                res_hit_q, res_hit_d;
  pos_t                res_cs_q, res_cs_d;
  pos_t                res_ce_q, res_ce_d;
  status_e             res_status_q, res_status_d;

  logic                out_valid_q, out_valid_d;
  logic                out_load;
  logic                out_hit_q;
  pos_t                out_cs_q, out_ce_q;
  status_e             out_status_q;

  logic                accept;
  logic                chrom_ok_in;
  logic [CNT_W-1:0]    n_eff;
  logic                site_in, overlap, match, last_slot;

  assign req_i.ready = (state_q == S_IDLE);
  assign accept      = req_i.valid && req_i.ready;
  assign chrom_ok_in = (32'(req_i.chrom_index) < CHROM_TOTAL);
  assign n_eff       = chrom_ok_q ? count_i : '0;

  assign site_in   = (first_q >= store_rdata_i.first) && (first_q <= store_rdata_i.last);
  assign overlap   = (store_rdata_i.first <= last_q) && (store_rdata_i.last >= first_q);
  assign match     = (op_q == OP_SITE) ? site_in : overlap;
  assign last_slot = ((CNT_W+1)'(slot_q) + (CNT_W+1)'(1)) == (CNT_W+1)'(n_q);

  always_comb begin
    state_d      = state_q;
    n_d          = n_q;
    slot_d       = slot_q;
    cnt_req_o    = '0;
    store_req_o  = '0;
    res_load     = 1'b0;
    res_hit_d    = 1'b0;
    res_cs_d     = '0;
    res_ce_d     = '0;
    res_status_d = ST_OK;
    out_load     = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          cnt_req_o.rd_en   = chrom_ok_in;
          cnt_req_o.rd_addr = CHROM_AW'(req_i.chrom_index);
          state_d           = S_COUNT;
        end
      end

      S_COUNT: begin
        case (op_q)
          OP_CLEAR: begin
            cnt_req_o.clear_all = 1'b1;
            res_load            = 1'b1;
            state_d             = S_REPLY;
          end
          OP_APPEND: begin
            if (!chrom_ok_q || (32'(count_i) >= MAX_INTERVALS)) begin
              res_status_d = ST_DROPPED;
            end else begin
              cnt_req_o.wr_en     = 1'b1;
              cnt_req_o.wr_addr   = chrom_q;
              cnt_req_o.wr_count  = count_i + CNT_W'(1);
              store_req_o.wr_en   = 1'b1;
              store_req_o.wr_addr = {chrom_q, SLOT_W'(count_i)};
              store_req_o.wr_data = '{first: first_q, last: last_q};
            end
            res_load = 1'b1;
            state_d  = S_REPLY;
          end
          default: begin
            if (!filter_enabled_i) begin
              res_hit_d = 1'b1;
              if (op_q == OP_RANGE) begin
                res_cs_d = first_q;
                res_ce_d = last_q;
              end
              res_load = 1'b1;
              state_d  = S_REPLY;
            end else if (n_eff == '0) begin
              res_load = 1'b1;
              state_d  = S_REPLY;
            end else begin
              store_req_o.rd_en   = 1'b1;
              store_req_o.rd_addr = {chrom_q, SLOT_W'(0)};
              n_d                 = n_eff;
              slot_d              = '0;
              state_d             = S_SCAN;
            end
          end
        endcase
      end

      S_SCAN: begin
        // The entry read last cycle is checked here; the next is fetched only if it neither matches nor is the last.
        if (match || last_slot) begin
          res_hit_d = match;
          if ((op_q == OP_RANGE) && match && (slot_q == '0)) begin
            res_cs_d = (first_q > store_rdata_i.first) ? first_q : store_rdata_i.first;
            res_ce_d = (last_q < store_rdata_i.last) ? last_q : store_rdata_i.last;
          end
          if ((op_q == OP_RANGE) && (n_q > CNT_W'(1))) begin
            res_status_d = ST_MULTI;
          end
          res_load = 1'b1;
          state_d  = S_REPLY;
        end else begin
          store_req_o.rd_en   = 1'b1;
          store_req_o.rd_addr = {chrom_q, slot_q + SLOT_W'(1)};
          slot_d              = slot_q + SLOT_W'(1);
        end
      end

      S_REPLY: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q       <= op_e'(req_i.opcode);
      chrom_q    <= CHROM_AW'(req_i.chrom_index);
      chrom_ok_q <= chrom_ok_in;
      first_q    <= POS_BITS'(req_i.first_pos);
      last_q     <= POS_BITS'(req_i.last_pos);
    end
    n_q    <= n_d;
    slot_q <= slot_d;
    if (res_load) begin
      res_hit_q    <= res_hit_d;
      res_cs_q     <= res_cs_d;
      res_ce_q     <= res_ce_d;
      res_status_q <= res_status_d;
    end
    if (out_load) begin
      out_hit_q    <= res_hit_q;
      out_cs_q     <= res_cs_q;
      out_ce_q     <= res_ce_q;
      out_status_q <= res_status_q;
    end
  end

  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.hit        = out_hit_q;
  assign rsp_o.clip_start = FIELD_W'(out_cs_q);
  assign rsp_o.clip_end   = FIELD_W'(out_ce_q);
  assign rsp_o.status     = out_status_q;

endmodule

`default_nettype wire

// File: tb/region_interval_filter_checker.sv
`default_nettype none

module region_interval_filter_checker
  import rif_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   cfg_we_i,
  input  wire logic   cfg_wdata_i,
  rif_in_if           req_i,
  rif_out_if          rsp_i,
  output int unsigned mismatch_count_o,
  output int unsigned pending_count_o
);

  typedef struct packed {
    logic               hit;
    logic [FIELD_W-1:0] clip_start;
    logic [FIELD_W-1:0] clip_end;
    status_e            status;
  } lookup_t;

  span_t       span_table [CHROM_TOTAL][MAX_INTERVALS];
  int unsigned span_count [CHROM_TOTAL];
  logic        filter_on;
  lookup_t     lookups_due [$];

  // Applies one word to the local copy of the table and returns the result it must give.
  function automatic lookup_t lookup_word(op_e op, logic [CHROM_W-1:0] chrom,
                                          logic [FIELD_W-1:0] first,
                                          logic [FIELD_W-1:0] last);
    lookup_t     res;
    pos_t        a;
    pos_t        b;
    span_t       s;
    int unsigned n;
    logic        known;
    logic        found;
    res    = '0;
    a      = pos_t'(first);
    b      = pos_t'(last);
    known  = (chrom < CHROM_TOTAL);
    found  = 1'b0;
    case (op)
      OP_CLEAR: begin
        foreach (span_count[c]) span_count[c] = 0;
      end
      OP_APPEND: begin
        if (!known || span_count[chrom] >= MAX_INTERVALS) begin
          res.status = ST_DROPPED;
        end else begin
          span_table[chrom][span_count[chrom]] = '{first: a, last: b};
          span_count[chrom]++;
        end
      end
      default: begin
        if (!filter_on) begin
          res.hit = 1'b1;
          if (op == OP_RANGE) begin
            res.clip_start = FIELD_W'(a);
            res.clip_end   = FIELD_W'(b);
          end
        end else begin
          n = known ? span_count[chrom] : 0;
          for (int unsigned i = 0; i < n && !found; i++) begin
            s = span_table[chrom][i];
            if (op == OP_SITE) begin
              found = (a >= s.first) && (a <= s.last);
            end else if (s.first <= b && s.last >= a) begin
              found = 1'b1;
              // Clipping only ever uses the first interval of the list.
              if (i == 0) begin
                res.clip_start = FIELD_W'((a > s.first) ? a : s.first);
                res.clip_end   = FIELD_W'((b < s.last) ? b : s.last);
              end
            end
          end
          res.hit = found;
          if (op == OP_RANGE && n > 1) res.status = ST_MULTI;
        end
      end
    endcase
    return res;
  endfunction

  function automatic void flag_mismatch(string field, logic [FIELD_W-1:0] want,
                                        logic [FIELD_W-1:0] got);
    $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
    mismatch_count_o++;
  endfunction

  always @(posedge clk_i) begin : watch
    lookup_t want;
    if (!rst_ni) begin
      filter_on = 1'b0;
      foreach (span_count[c]) span_count[c] = 0;
      lookups_due.delete();
      mismatch_count_o = 0;
    end else begin
      if (rsp_i.valid && rsp_i.ready) begin
        if (lookups_due.size() == 0) begin
          $display({"%0t: result word with none expected, ",
                    "actual hit %0b start 0x%0h end 0x%0h status %0d"},
                   $time, rsp_i.hit, rsp_i.clip_start, rsp_i.clip_end, rsp_i.status);
          mismatch_count_o++;
        end else begin
          want = lookups_due.pop_front();
          if (rsp_i.hit !== want.hit)
            flag_mismatch("hit", FIELD_W'(want.hit), FIELD_W'(rsp_i.hit));
          if (rsp_i.clip_start !== want.clip_start)
            flag_mismatch("clip_start", want.clip_start, rsp_i.clip_start);
          if (rsp_i.clip_end !== want.clip_end)
            flag_mismatch("clip_end", want.clip_end, rsp_i.clip_end);
          if (rsp_i.status !== want.status)
            flag_mismatch("status", FIELD_W'(want.status), FIELD_W'(rsp_i.status));
        end
      end
      if (cfg_we_i) filter_on = cfg_wdata_i;
      if (req_i.valid && req_i.ready) begin
        lookups_due.push_back(lookup_word(op_e'(req_i.opcode), req_i.chrom_index,
                                          req_i.first_pos, req_i.last_pos));
      end
    end
    pending_count_o = lookups_due.size();
  end

endmodule

`default_nettype wire

// File: tb/region_interval_filter_core_tb.sv
`default_nettype none

module region_interval_filter_core_tb;
  import rif_pkg::*;

  localparam int unsigned STALL_LIMIT    = 2000;
  localparam int unsigned LONG_HOLD      = 200;
  localparam int unsigned LONG_HOLD_AT   = 400;
  localparam int unsigned DRAIN_CYCLES   = 40;
  localparam int unsigned PHASES         = 9;
  localparam int unsigned WORDS_PER_PASS = 150;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        cfg_we    = 1'b0;
  logic        cfg_wdata = 1'b0;
  logic        quiet     = 1'b0;
  int unsigned mismatches;
  int unsigned pending;
  int unsigned results_taken = 0;
  int unsigned stall_cycles  = 0;

  rif_in_if  req_if ();
  rif_out_if rsp_if ();

  region_interval_filter_core i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .req_i       (req_if),
    .rsp_o       (rsp_if)
  );

  region_interval_filter_checker i_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_we_i         (cfg_we),
    .cfg_wdata_i      (cfg_wdata),
    .req_i            (req_if),
    .rsp_i            (rsp_if),
    .mismatch_count_o (mismatches),
    .pending_count_o  (pending)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    if (!rst_n || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Called at a falling edge; returns at the falling edge after the word was taken.
  task automatic push_word(input op_e op, input logic [CHROM_W-1:0] chrom,
                           input logic [FIELD_W-1:0] first, input logic [FIELD_W-1:0] last);
    int unsigned gap;
    gap = quiet ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_if.valid       <= 1'b1;
    req_if.opcode      <= op;
    req_if.chrom_index <= chrom;
    req_if.first_pos   <= first;
    req_if.last_pos    <= last;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic settle();
    req_if.valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  task automatic program_filter(input logic enable);
    cfg_wdata <= enable;
    cfg_we    <= 1'b1;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Mostly positions near zero or near the top, so that intervals and queries meet.
  function automatic pos_t draw_pos();
    case ($urandom_range(0, 9))
      0, 1:    return 32'hFFFF_FFFF - $urandom_range(0, 1500);
      2:       return $urandom;
      default: return $urandom_range(0, 1500);
    endcase
  endfunction

  task automatic random_word(input int unsigned chrom_top);
    int unsigned  pick;
    int unsigned  clear_pct;
    op_e          op;
    pos_t         a;
    pos_t         b;
    // Narrow passes never clear, so their few lists fill up and appends get dropped.
    clear_pct = (chrom_top < 8) ? 0 : 2;
    pick      = $urandom_range(0, 99);
    if (pick < clear_pct)     op = OP_CLEAR;
    else if (pick < 36)       op = OP_APPEND;
    else if (pick < 68)       op = OP_SITE;
    else                      op = OP_RANGE;
    a = draw_pos();
    case ($urandom_range(0, 9))
      0:       b = $urandom;
      1:       b = a - $urandom_range(1, 50);
      default: b = a + $urandom_range(0, 300);
    endcase
    push_word(op, CHROM_W'($urandom_range(0, chrom_top)), a, b);
  endtask

  initial begin : feed_results
    int unsigned wait_cycles;
    rsp_if.ready = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      wait_cycles = quiet ? 0 : $urandom_range(0, 4);
      // One long hold-off lets the block fill up and push back on its input.
      if (results_taken == LONG_HOLD_AT) wait_cycles = LONG_HOLD;
      if (wait_cycles > 0) begin
        rsp_if.ready <= 1'b0;
        repeat (wait_cycles) @(negedge clk);
      end
      rsp_if.ready <= 1'b1;
      @(posedge clk);
      while (!rsp_if.valid) @(posedge clk);
      results_taken++;
      @(negedge clk);
    end
  end

  initial begin : stimulus
    req_if.valid       = 1'b0;
    req_if.opcode      = OP_CLEAR;
    req_if.chrom_index = '0;
    req_if.first_pos   = '0;
    req_if.last_pos    = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Filter disabled after reset: queries hit and ranges pass through.
    push_word(OP_SITE,   6'd0,  32'h0000_1234, 32'h0);
    push_word(OP_RANGE,  6'd63, 32'hFFFF_FFFF, 32'h0);
    push_word(OP_APPEND, 6'd2,  32'd10,        32'd20);
    push_word(OP_APPEND, 6'd2,  32'd100,       32'd200);
    push_word(OP_CLEAR,  6'd0,  32'h0,         32'h0);
    push_word(OP_APPEND, 6'd2,  32'd10,        32'd20);
    push_word(OP_APPEND, 6'd2,  32'd100,       32'd200);
    settle();
    program_filter(1'b1);

    push_word(OP_SITE,   6'd5,  32'd7,         32'd0);
    push_word(OP_RANGE,  6'd5,  32'd0,         32'hFFFF_FFFF);
    push_word(OP_SITE,   6'd2,  32'd15,        32'd0);
    push_word(OP_SITE,   6'd2,  32'd50,        32'd0);
    // Misses the first interval but overlaps the second.
    push_word(OP_RANGE,  6'd2,  32'd150,       32'd300);
    push_word(OP_RANGE,  6'd2,  32'd5,         32'd12);
    push_word(OP_RANGE,  6'd2,  32'd300,       32'd150);
    push_word(OP_APPEND, 6'd0,  32'h0,         32'h0);
    push_word(OP_APPEND, 6'd0,  32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_word(OP_SITE,   6'd0,  32'h0,         32'h0);
    push_word(OP_SITE,   6'd0,  32'hFFFF_FFFF, 32'h0);
    push_word(OP_RANGE,  6'd0,  32'h0,         32'hFFFF_FFFF);
    // A reversed interval can hold no site, yet a wide range still overlaps it.
    push_word(OP_APPEND, 6'd1,  32'd100,       32'd50);
    push_word(OP_SITE,   6'd1,  32'd75,        32'd0);
    push_word(OP_RANGE,  6'd1,  32'd0,         32'hFFFF_FFFF);

    for (int unsigned phase = 0; phase < PHASES; phase++) begin
      settle();
      quiet = (phase % 4 == 2);
      program_filter(phase % 3 != 1);
      for (int unsigned k = 0; k < WORDS_PER_PASS; k++) begin
        random_word((phase % 2 == 0) ? 1 : CHROM_W'(CHROM_TOTAL - 1));
      end
    end

    settle();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

`default_nettype wire
